/* hw/rtl/roc_pkg.sv */
// Shared types, constants and tables for the ray/rectangle occlusion core.
// Holds the item structs, the sequencer state enum and the CORDIC angle table.
// No dependencies.
package roc_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 64;
    localparam int CFG_W               = 7;
    localparam int SLOT_W              = 6;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int STEP_W       = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int DIFF_W    = 19;
    localparam int PROD_W    = CORDIC_W + DIFF_W;
    localparam int SQ_IN_W   = 38;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int DIST_W    = SQ_ROOT_W - 1;
    localparam int POS_W     = 24;
    localparam int ROUND_SH  = 30;

    typedef struct packed {
        logic               mode;
        logic [5:0]         entry_index;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
        logic               blocks_light;
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic [15:0]        light_radius;
        logic [15:0]        ray_angle;
        logic               casts_shadows;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        ray_length;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               was_blocked;
    } out_item_t;

    typedef struct packed {
        logic               blocks;
        logic signed [15:0] top;
        logic signed [15:0] left;
        logic [15:0]        height;
        logic [15:0]        width;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_READ,
        ST_CHECK,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_SQRT,
        ST_PX,
        ST_PY,
        ST_TEST,
        ST_FIN_X,
        ST_FIN_Y,
        ST_END,
        ST_OUT
    } state_t;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CAST = 1'b1;

    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [POS_W-1:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767)
            r = 16'sh7FFF;
        else if (v < -24'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* hw/rtl/roc_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on roc_pkg for widths.
module roc_isqrt
    import roc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQ_IN_W-1:0]   radicand,
    output logic                 done,
    output logic [SQ_ROOT_W-1:0] root
);

    localparam int REM_W = SQ_ROOT_W + 2;
    localparam int CNT_W = $clog2(SQ_ROOT_W + 1);

    logic [SQ_IN_W-1:0]   rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic             take;

    assign rem_shift = {rem_reg, rad_reg[SQ_IN_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SQ_ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[SQ_IN_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_shift);
                root_reg <= {root_reg[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("square root restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("square root done without a run");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < CNT_W'(SQ_ROOT_W))
        else $error("square root step count out of range");

endmodule

/* hw/rtl/ray_rectangle_occlusion_core.sv */
// Ray versus rectangle occlusion core: rectangle table, CORDIC and entry walk.
// Depends on roc_pkg and roc_isqrt.
//
// Usage:
//   in_valid/in_ready/in_data carry one item. A load item (mode 0) writes one
//   table slot and completes in the cycle it is accepted; it gives no result.
//   A cast item (mode 1) gives exactly one result on out_valid/out_ready/
//   out_data. cfg_we/cfg_data write entry_count; the user must write it only
//   while the core is idle, as the core itself does not enforce this.
//   A cast runs the CORDIC steps for sine and cosine, then, if casts_shadows
//   is set, reads and checks each of the first entry_count slots (at most
//   MAX_ENTRIES); a blocking entry also takes the squares on the shared
//   multiplier and the bit-per-cycle square root, and within the radius the
//   offsets and the rectangle test. The end point and the output register
//   follow. The square root unit and the single multiplier bound its run time.
//   in_ready is high only while the sequencer is idle. A finished result sits
//   in the output register; the core takes new items while it waits, and a
//   following cast holds in its last step until the register frees up.
//   Reset clears the sequencer, the output valid and entry_count; table
//   contents are undefined until loaded, and no clearing pass runs.
module ray_rectangle_occlusion_core
    import roc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] entry_count_reg;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_word_reg;
    logic   mem_we;
    logic [31:0]   slot_ext;
    logic [AW-1:0] wr_addr;

    logic signed [15:0] lx_reg, ly_reg;
    logic [15:0]        radius_reg;
    logic               casts_reg;
    logic               flip_reg;
    logic [CNT_W-1:0]   n_reg, idx_reg;
    logic [31:0]        n_full;
    logic [CNT_W-1:0]   idx_inc;

    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [CORDIC_W-1:0] cs, sn, atan_s;
    logic [31:0]                turn;

    logic signed [15:0] left_reg, top_reg;
    logic [15:0]        w_reg, h_reg;
    logic signed [DIFF_W-1:0] dx2_reg, dy2_reg;
    logic signed [DIFF_W-1:0] dx2_c, dy2_c;
    logic [SQ_IN_W-1:0]       sq_reg;
    logic [DIST_W-1:0]        d_reg;
    logic [DIST_W-1:0]        d_c;
    logic signed [POS_W-1:0]  px_reg;

    logic signed [CORDIC_W-1:0] mul_a;
    logic signed [DIFF_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [POS_W-1:0]    off;
    logic signed [POS_W-1:0]    pos_x, pos_y;

    logic [15:0]        best_reg;
    logic               hit_reg;
    logic signed [15:0] end_x_reg;
    logic signed [15:0] end_y_reg;

    logic               in_rect;
    logic               sqrt_start, sqrt_done;
    logic [SQ_ROOT_W-1:0] sqrt_root;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      out_load;

    logic accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // table write port and registered read port
    assign slot_ext = {26'd0, in_data.entry_index};
    assign wr_addr  = slot_ext[AW-1:0];
    assign mem_we   = accept && (in_data.mode == MODE_LOAD) && (slot_ext < 32'(MAX_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= '{blocks: in_data.blocks_light, top: in_data.rect_top,
                              left: in_data.rect_left, height: in_data.rect_height,
                              width: in_data.rect_width};
        rd_word_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= '0;
        else if (cfg_we)
            entry_count_reg <= cfg_data;
    end

    assign n_full = (32'(entry_count_reg) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                                                              : 32'(entry_count_reg);
    assign idx_inc = idx_reg + 1'b1;

    // CORDIC helpers
    assign turn   = {in_data.ray_angle[15] ^ (in_data.ray_angle[15] ^ in_data.ray_angle[14]),
                     in_data.ray_angle[14:0], 16'd0};
    assign atan_s = CORDIC_W'(atan_turn(step_reg));
    assign cs     = flip_reg ? -cx_reg : cx_reg;
    assign sn     = flip_reg ? -cy_reg : cy_reg;

    // entry geometry
    assign dx2_c = DIFF_W'(signed'({rd_word_reg.left, 1'b0})) + DIFF_W'({1'b0, rd_word_reg.width})
                 - DIFF_W'(signed'({lx_reg, 1'b0}));
    assign dy2_c = DIFF_W'(signed'({rd_word_reg.top, 1'b0})) + DIFF_W'({1'b0, rd_word_reg.height})
                 - DIFF_W'(signed'({ly_reg, 1'b0}));
    assign d_c   = sqrt_root[SQ_ROOT_W-1:1];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = CORDIC_W'(dx2_reg);
                mul_b = dx2_reg;
            end
            ST_SQY:
            begin
                mul_a = CORDIC_W'(dy2_reg);
                mul_b = dy2_reg;
            end
            ST_PX:
            begin
                mul_a = cs;
                mul_b = signed'({1'b0, d_reg});
            end
            ST_PY:
            begin
                mul_a = sn;
                mul_b = signed'({1'b0, d_reg});
            end
            ST_FIN_X:
            begin
                mul_a = cs;
                mul_b = signed'({3'b000, best_reg});
            end
            ST_FIN_Y:
            begin
                mul_a = sn;
                mul_b = signed'({3'b000, best_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
    end

    assign prod_rnd = prod_reg + (PROD_W'(1) <<< (ROUND_SH - 1));
    assign off      = POS_W'(prod_rnd >>> ROUND_SH);
    assign pos_x    = POS_W'(lx_reg) + off;
    assign pos_y    = POS_W'(ly_reg) + off;

    assign in_rect = (px_reg >= POS_W'(left_reg))
                  && (px_reg < POS_W'(left_reg) + POS_W'(signed'({1'b0, w_reg})))
                  && (pos_y >= POS_W'(top_reg))
                  && (pos_y < POS_W'(top_reg) + POS_W'(signed'({1'b0, h_reg})));

    assign sqrt_start = (state_reg == ST_SUM);

    roc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg + prod_reg[SQ_IN_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && in_data.mode == MODE_CAST)
                    state_next = ST_CORDIC;
            ST_CORDIC:
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = (casts_reg && n_reg != '0) ? ST_READ : ST_FIN_X;
            ST_READ:
                state_next = ST_CHECK;
            ST_CHECK:
                if (rd_word_reg.blocks)
                    state_next = ST_SQX;
                else
                    state_next = (idx_inc == n_reg) ? ST_FIN_X : ST_READ;
            ST_SQX:
                state_next = ST_SQY;
            ST_SQY:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_SQRT;
            ST_SQRT:
                if (sqrt_done)
                begin
                    if (d_c > DIST_W'(radius_reg))
                        state_next = (idx_inc == n_reg) ? ST_FIN_X : ST_READ;
                    else
                        state_next = ST_PX;
                end
            ST_PX:
                state_next = ST_PY;
            ST_PY:
                state_next = ST_TEST;
            ST_TEST:
                state_next = (idx_inc == n_reg) ? ST_FIN_X : ST_READ;
            ST_FIN_X:
                state_next = ST_FIN_Y;
            ST_FIN_Y:
                state_next = ST_END;
            ST_END:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        step_reg <= '0;
                        idx_reg  <= '0;
                        hit_reg  <= 1'b0;
                        n_reg    <= n_full[CNT_W-1:0];
                    end
                ST_CORDIC:
                    step_reg <= step_reg + 1'b1;
                ST_CHECK:
                    if (!rd_word_reg.blocks)
                        idx_reg <= idx_inc;
                ST_SQRT:
                    if (sqrt_done && d_c > DIST_W'(radius_reg))
                        idx_reg <= idx_inc;
                ST_TEST:
                begin
                    idx_reg <= idx_inc;
                    if (in_rect)
                        hit_reg <= 1'b1;
                end
                default:
                    step_reg <= step_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    lx_reg     <= in_data.light_x;
                    ly_reg     <= in_data.light_y;
                    radius_reg <= in_data.light_radius;
                    casts_reg  <= in_data.casts_shadows;
                    flip_reg   <= in_data.ray_angle[15] ^ in_data.ray_angle[14];
                    cx_reg     <= CORDIC_GAIN;
                    cy_reg     <= '0;
                    cz_reg     <= CORDIC_W'(signed'(turn));
                end
            ST_CORDIC:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - (cy_reg >>> step_reg);
                    cy_reg <= cy_reg + (cx_reg >>> step_reg);
                    cz_reg <= cz_reg - atan_s;
                end
                else
                begin
                    cx_reg <= cx_reg + (cy_reg >>> step_reg);
                    cy_reg <= cy_reg - (cx_reg >>> step_reg);
                    cz_reg <= cz_reg + atan_s;
                end
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    best_reg <= radius_reg;
            end
            ST_CHECK:
            begin
                left_reg <= rd_word_reg.left;
                top_reg  <= rd_word_reg.top;
                w_reg    <= rd_word_reg.width;
                h_reg    <= rd_word_reg.height;
                dx2_reg  <= dx2_c;
                dy2_reg  <= dy2_c;
            end
            ST_SQY:
                sq_reg <= prod_reg[SQ_IN_W-1:0];
            ST_SQRT:
                if (sqrt_done)
                    d_reg <= d_c;
            ST_PY:
                px_reg <= pos_x;
            ST_TEST:
                if (in_rect && (!hit_reg || d_reg < DIST_W'(best_reg)))
                    best_reg <= d_reg[15:0];
            ST_FIN_Y:
                end_x_reg <= sat16(pos_x);
            ST_END:
                end_y_reg <= sat16(pos_y);
            ST_OUT:
                if (out_load)
                begin
                    out_data_reg.ray_length  <= best_reg;
                    out_data_reg.end_x       <= end_x_reg;
                    out_data_reg.end_y       <= end_y_reg;
                    out_data_reg.was_blocked <= hit_reg;
                end
            default:
                sq_reg <= sq_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_test_within_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> d_reg <= DIST_W'(radius_reg))
        else $error("entry tested beyond the radius");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> idx_reg < n_reg)
        else $error("walk past the entry count");

    a_hit_best: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_reg && state_reg != ST_IDLE) |-> best_reg <= radius_reg)
        else $error("hit distance above radius");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result not presented after load");

endmodule
